// ===== design/t8ie_pkg.sv =====
`default_nettype none
// ============================================================================
// t8ie_pkg
// Shared constants, codes and types of the tiny 8-bit instruction executor.
// ============================================================================
package t8ie_pkg;

    localparam int ADDR_BITS = 16;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_SET_PC = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_STEP   = 2'd3;

    localparam logic [7:0] OP_NOP     = 8'hea;
    localparam logic [7:0] OP_LDA_IMM = 8'ha9;
    localparam logic [7:0] OP_LDA_ZP  = 8'ha5;
    localparam logic [7:0] OP_STA_ZP  = 8'h85;
    localparam logic [7:0] OP_STA_ABS = 8'h8d;
    localparam logic [7:0] OP_SEC     = 8'h38;
    localparam logic [7:0] OP_CLC     = 8'h18;
    localparam logic [7:0] OP_ADC_IMM = 8'h69;
    localparam logic [7:0] OP_INX     = 8'he8;
    localparam logic [7:0] OP_BCS     = 8'hb0;
    localparam logic [7:0] OP_JMP_ABS = 8'h4c;

    typedef enum logic [1:0] {
        ALU_INC,
        ALU_REL,
        ALU_ADC
    } alu_op_t;

    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] addr;
        logic [7:0]           wdata;
    } mem_req_t;

    typedef struct packed {
        logic [7:0]  executed_opcode;
        logic [15:0] program_counter;
        logic [7:0]  acc;
        logic [7:0]  index_x;
        logic        carry_flag;
        logic        zero_flag;
        logic [7:0]  read_data;
    } result_t;

    // True for opcodes that carry at least one operand byte.
    function automatic logic op_has_operand(input logic [7:0] op);
        return op inside {OP_LDA_IMM, OP_LDA_ZP, OP_STA_ZP, OP_STA_ABS,
                          OP_ADC_IMM, OP_BCS, OP_JMP_ABS};
    endfunction

endpackage
`default_nettype wire

// ===== design/t8ie_if.sv =====
`default_nettype none
// ============================================================================
// t8ie_if
// Valid/ready channels for command words and result words.
// ============================================================================
interface t8ie_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source(output valid, output mode, output address, output write_data,
                   input ready);
    modport sink(input valid, input mode, input address, input write_data,
                 output ready);
endinterface

interface t8ie_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  executed_opcode;
    logic [15:0] program_counter;
    logic [7:0]  acc;
    logic [7:0]  index_x;
    logic        carry_flag;
    logic        zero_flag;
    logic [7:0]  read_data;

    modport source(output valid, output executed_opcode, output program_counter,
                   output acc, output index_x, output carry_flag,
                   output zero_flag, output read_data, input ready);
    modport sink(input valid, input executed_opcode, input program_counter,
                 input acc, input index_x, input carry_flag, input zero_flag,
                 input read_data, output ready);
endinterface
`default_nettype wire

// ===== design/t8ie_mem.sv =====
`default_nettype none
// ============================================================================
// t8ie_mem
// Single-port byte memory with a registered read.
// ============================================================================
module t8ie_mem (
    input  wire logic              clk,
    input  wire t8ie_pkg::mem_req_t req,
    output logic [7:0]             rdata
);

    logic [7:0] mem_array [0:t8ie_pkg::MEM_DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_array[req.addr] <= req.wdata;
        end
        rdata <= mem_array[req.addr];
    end

endmodule
`default_nettype wire

// ===== design/t8ie_alu.sv =====
`default_nettype none
// ============================================================================
// t8ie_alu
// Shared adder for program counter increments, branch targets and ADC.
// ============================================================================
module t8ie_alu (
    input  wire t8ie_pkg::alu_op_t          op,
    input  wire logic [t8ie_pkg::ADDR_BITS-1:0] pc,
    input  wire logic [7:0]                 acc,
    input  wire logic [7:0]                 operand,
    input  wire logic                       carry_in,
    output logic [16:0]                     sum
);

    logic [15:0] opa;
    logic [15:0] opb;
    logic        cin;

    always_comb
    begin
        opa = 16'(pc);
        opb = 16'd1;
        cin = 1'b0;
        case (op)
            t8ie_pkg::ALU_INC:
            begin
                opb = 16'd1;
            end
            t8ie_pkg::ALU_REL:
            begin
                opb = {{8{operand[7]}}, operand};
            end
            t8ie_pkg::ALU_ADC:
            begin
                opa = {8'd0, acc};
                opb = {8'd0, operand};
                cin = carry_in;
            end
            default:
            begin
                opb = 16'd1;
            end
        endcase
        sum = {1'b0, opa} + {1'b0, opb} + 17'(cin);
    end

endmodule
`default_nettype wire

// ===== design/tiny_8bit_instruction_executor.sv =====
`default_nettype none
// ============================================================================
// tiny_8bit_instruction_executor
// Small 8-bit CPU subset that runs over an internal byte memory.
// ============================================================================
// Each command word on in_ch writes a memory byte, sets the program counter,
// reads a memory byte or steps one instruction. Every command word yields
// exactly one result word on out_ch with the registers after the command.
// A sequencer drives one memory port and one shared adder. A write or a
// PC load goes from acceptance to S_DONE and then the result register; a
// read passes S_READ first; a step passes S_OPCODE, then S_OPER1 for the
// first operand byte, S_OPER2 for a second and S_ZPREAD for a zero-page
// load. Every byte moves through the memory port with a registered read.
// in_ch.ready is high only while the sequencer is idle, so the block holds
// one command at a time; it takes the next command while the previous
// result still waits in the output register. The next command word is
// accepted in the cycle after the result register loads, so a new command
// starts only once the previous one has reached the result register.
// When out_ch stalls, a finished command waits until the output register
// is free.
// Reset clears the program counter, A, X, carry and zero; memory contents
// are undefined until written.
// ============================================================================
module tiny_8bit_instruction_executor (
    input  wire logic   clk,
    input  wire logic   rst_n,
    t8ie_in_if.sink     in_ch,
    t8ie_out_if.source  out_ch
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_OPCODE,
        S_OPER1,
        S_ZPREAD,
        S_OPER2,
        S_DONE
    } state_t;

    localparam int AW = t8ie_pkg::ADDR_BITS;

    state_t              state_reg,     state_next;
    logic [AW-1:0]       pc_reg,        pc_next;
    logic [7:0]          acc_reg,       acc_next;
    logic [7:0]          x_reg,         x_next;
    logic                carry_reg,     carry_next;
    logic                zero_reg,      zero_next;
    logic [7:0]          opcode_reg,    opcode_next;
    logic [7:0]          lo_reg,        lo_next;
    logic [7:0]          rd_reg,        rd_next;
    logic                out_valid_reg, out_valid_next;
    t8ie_pkg::result_t   out_reg,       out_next;

    t8ie_pkg::mem_req_t  mem_req;
    logic [7:0]          mem_rdata;
    t8ie_pkg::alu_op_t   alu_op;
    logic [16:0]         alu_sum;
    logic [AW-1:0]       pc_sum;

    t8ie_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    t8ie_alu u_alu (
        .op       (alu_op),
        .pc       (pc_reg),
        .acc      (acc_reg),
        .operand  (mem_rdata),
        .carry_in (carry_reg),
        .sum      (alu_sum)
    );

    assign pc_sum      = AW'(alu_sum);
    assign in_ch.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        acc_next       = acc_reg;
        x_next         = x_reg;
        carry_next     = carry_reg;
        zero_next      = zero_reg;
        opcode_next    = opcode_reg;
        lo_next        = lo_reg;
        rd_next        = rd_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        mem_req.we     = 1'b0;
        mem_req.addr   = pc_reg;
        mem_req.wdata  = acc_reg;
        alu_op         = t8ie_pkg::ALU_INC;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    opcode_next = 8'd0;
                    rd_next     = 8'd0;
                    case (in_ch.mode)
                        t8ie_pkg::MODE_WRITE:
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.addr  = in_ch.address[AW-1:0];
                            mem_req.wdata = in_ch.write_data;
                            state_next    = S_DONE;
                        end
                        t8ie_pkg::MODE_SET_PC:
                        begin
                            pc_next    = in_ch.address[AW-1:0];
                            state_next = S_DONE;
                        end
                        t8ie_pkg::MODE_READ:
                        begin
                            mem_req.addr = in_ch.address[AW-1:0];
                            state_next   = S_READ;
                        end
                        default:
                        begin
                            pc_next    = pc_sum;
                            state_next = S_OPCODE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rd_next    = mem_rdata;
                state_next = S_DONE;
            end
            S_OPCODE:
            begin
                opcode_next = mem_rdata;
                state_next  = S_DONE;
                if (t8ie_pkg::op_has_operand(mem_rdata))
                begin
                    pc_next    = pc_sum;
                    state_next = S_OPER1;
                end
                else
                begin
                    case (mem_rdata)
                        t8ie_pkg::OP_SEC: carry_next = 1'b1;
                        t8ie_pkg::OP_CLC: carry_next = 1'b0;
                        t8ie_pkg::OP_INX: x_next     = x_reg + 8'd1;
                        default:          x_next     = x_reg;
                    endcase
                end
            end
            S_OPER1:
            begin
                lo_next    = mem_rdata;
                state_next = S_DONE;
                case (opcode_reg)
                    t8ie_pkg::OP_LDA_IMM:
                    begin
                        acc_next = mem_rdata;
                    end
                    t8ie_pkg::OP_LDA_ZP:
                    begin
                        mem_req.addr = AW'(mem_rdata);
                        state_next   = S_ZPREAD;
                    end
                    t8ie_pkg::OP_STA_ZP:
                    begin
                        mem_req.we   = 1'b1;
                        mem_req.addr = AW'(mem_rdata);
                    end
                    t8ie_pkg::OP_ADC_IMM:
                    begin
                        alu_op     = t8ie_pkg::ALU_ADC;
                        acc_next   = alu_sum[7:0];
                        carry_next = alu_sum[8];
                        zero_next  = (alu_sum[7:0] == 8'd0);
                    end
                    t8ie_pkg::OP_BCS:
                    begin
                        alu_op = t8ie_pkg::ALU_REL;
                        if (carry_reg)
                        begin
                            pc_next = pc_sum;
                        end
                    end
                    default:
                    begin
                        pc_next    = pc_sum;
                        state_next = S_OPER2;
                    end
                endcase
            end
            S_ZPREAD:
            begin
                acc_next   = mem_rdata;
                state_next = S_DONE;
            end
            S_OPER2:
            begin
                state_next = S_DONE;
                if (opcode_reg == t8ie_pkg::OP_STA_ABS)
                begin
                    mem_req.we   = 1'b1;
                    mem_req.addr = AW'({mem_rdata, lo_reg});
                end
                else
                begin
                    pc_next = AW'({mem_rdata, lo_reg});
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_next.executed_opcode = opcode_reg;
                    out_next.program_counter = 16'(pc_reg);
                    out_next.acc             = acc_reg;
                    out_next.index_x         = x_reg;
                    out_next.carry_flag      = carry_reg;
                    out_next.zero_flag       = zero_reg;
                    out_next.read_data       = rd_reg;
                    out_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            acc_reg       <= 8'd0;
            x_reg         <= 8'd0;
            carry_reg     <= 1'b0;
            zero_reg      <= 1'b0;
            opcode_reg    <= 8'd0;
            lo_reg        <= 8'd0;
            rd_reg        <= 8'd0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            acc_reg       <= acc_next;
            x_reg         <= x_next;
            carry_reg     <= carry_next;
            zero_reg      <= zero_next;
            opcode_reg    <= opcode_next;
            lo_reg        <= lo_next;
            rd_reg        <= rd_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.executed_opcode = out_reg.executed_opcode;
    assign out_ch.program_counter = out_reg.program_counter;
    assign out_ch.acc             = out_reg.acc;
    assign out_ch.index_x         = out_reg.index_x;
    assign out_ch.carry_flag      = out_reg.carry_flag;
    assign out_ch.zero_flag       = out_reg.zero_flag;
    assign out_ch.read_data       = out_reg.read_data;

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> (state_reg != S_IDLE))
        else $error("Accepted command word did not start the sequencer.");

    assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (state_reg == S_IDLE || state_reg == S_OPER1 ||
                        state_reg == S_OPER2))
        else $error("Memory write issued from an unexpected state.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!out_valid_reg || out_ch.ready))
        |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("Finished command word was not moved to the output register.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready && state_reg == S_DONE)
        |=> (state_reg == S_DONE))
        else $error("Result word lost while the output was stalled.");

endmodule
`default_nettype wire
